### rtl/nbtrie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nbtrie_pkg;

    localparam int NodeDepthDefault = 16384;
    // widest node address over the allowed depth range
    localparam int MemAddrMaxW = 15;
    localparam int LeafBit = 15;
    localparam logic [3:0] CountMax = 4'hF;

    typedef enum logic [1:0] {
        ST_NEED   = 2'd0,
        ST_FOLDED = 2'd1,
        ST_NOFOLD = 2'd2
    } t_status;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_LOOKUP = 1'b1
    } t_kind;

    localparam logic [1:0] MODE_8  = 2'd0;
    localparam logic [1:0] MODE_16 = 2'd1;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    typedef struct packed {
        logic                   wr_en;
        logic [MemAddrMaxW-1:0] wr_addr;
        logic [15:0]            wr_data;
        logic                   rd_en;
        logic [MemAddrMaxW-1:0] rd_addr;
    } t_mem_req;

    function automatic logic [3:0] nibble_of(input logic [31:0] unit, input logic [2:0] idx);
        logic [3:0] nib;
        nib = unit[{idx, 2'b00} +: 4];
        return nib;
    endfunction

endpackage
`default_nettype wire

### rtl/nbtrie_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module nbtrie_mem #(
    parameter int NODE_DEPTH = nbtrie_pkg::NodeDepthDefault
) (
    input  wire                  i_clk,
    input  nbtrie_pkg::t_mem_req i_req,
    output logic [15:0]          o_rd_data
);

    localparam int AddrW = $clog2(NODE_DEPTH);

    logic [15:0] r_mem [NODE_DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AddrW-1:0]] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[AddrW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### rtl/nbtrie_walk.sv
`timescale 1ns / 1ps
`default_nettype none
module nbtrie_walk #(
    parameter int NODE_DEPTH = nbtrie_pkg::NodeDepthDefault
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire                   i_kind,
    input  wire  [13:0]           i_node_addr,
    input  wire  [15:0]           i_node_word,
    input  wire  [31:0]           i_code_unit,
    input  wire                   i_start_req,
    input  wire                   i_cfg_we,
    input  wire  [1:0]            i_cfg_wdata,
    output nbtrie_pkg::t_mem_req  o_mem_req,
    input  wire  [15:0]           i_mem_rdata,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [14:0]           o_leaf_index,
    output logic [3:0]            o_units_consumed
);

    localparam int MaxW = nbtrie_pkg::MemAddrMaxW;

    nbtrie_pkg::t_state  r_state, n_state;
    logic [1:0]          r_mode;
    logic [14:0]         r_base, n_base;
    logic [3:0]          r_count, n_count;
    logic                r_active, n_active;
    logic [31:0]         r_unit, n_unit;
    logic [2:0]          r_idx, n_idx;
    logic                r_rd_ok, n_rd_ok;
    logic                r_valid, n_valid;
    nbtrie_pkg::t_status r_status, n_status;
    logic [14:0]         r_leaf, n_leaf;
    logic [3:0]          r_units, n_units;

    logic [31:0] unit_m;
    logic [2:0]  top_idx;
    logic        trail;
    logic [15:0] node;
    logic [3:0]  count_inc;
    logic        rd_go;
    logic [15:0] rd_base;
    logic [3:0]  rd_nib;
    logic [16:0] rd_sum;
    logic [2:0]  next_idx;

    always_comb begin
        case (r_mode)
            nbtrie_pkg::MODE_8: begin
                unit_m  = {24'd0, i_code_unit[7:0]};
                top_idx = 3'd1;
            end
            nbtrie_pkg::MODE_16: begin
                unit_m  = {16'd0, i_code_unit[15:0]};
                top_idx = 3'd3;
            end
            default: begin
                unit_m  = i_code_unit;
                top_idx = 3'd7;
            end
        endcase
    end

    // continuation byte or low surrogate at the head of a lookup
    assign trail = (r_mode == nbtrie_pkg::MODE_8 && unit_m[7:6] == 2'b10) ||
                   (r_mode == nbtrie_pkg::MODE_16 && unit_m[15:10] == 6'b110111);

    assign node      = r_rd_ok ? i_mem_rdata : 16'd0;
    assign count_inc = (r_count == nbtrie_pkg::CountMax) ? r_count : r_count + 4'd1;
    assign next_idx  = r_idx - 3'd1;
    assign rd_sum    = 17'(rd_base) + 17'(rd_nib);

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_count  = r_count;
        n_active = r_active;
        n_unit   = r_unit;
        n_idx    = r_idx;
        n_valid  = 1'b0;
        n_status = nbtrie_pkg::ST_NOFOLD;
        n_leaf   = 15'd0;
        n_units  = 4'd0;
        rd_go    = 1'b0;
        rd_base  = 16'd0;
        rd_nib   = 4'd0;
        o_mem_req         = '0;
        o_mem_req.wr_addr = MaxW'(i_node_addr);
        o_mem_req.wr_data = i_node_word;
        case (r_state)
            nbtrie_pkg::S_IDLE: begin
                if (start) begin
                    if (i_kind == nbtrie_pkg::KIND_WRITE) begin
                        o_mem_req.wr_en = (17'(i_node_addr) < 17'(NODE_DEPTH));
                    end else if (i_start_req) begin
                        n_base   = 15'd0;
                        n_count  = 4'd0;
                        n_active = 1'b1;
                        if (trail) begin
                            n_active = 1'b0;
                            n_valid  = 1'b1;
                        end else begin
                            rd_go   = 1'b1;
                            rd_base = 16'd0;
                        end
                    end else if (r_active) begin
                        if (unit_m == 32'd0) begin
                            n_active = 1'b0;
                            n_valid  = 1'b1;
                        end else begin
                            rd_go   = 1'b1;
                            rd_base = {1'b0, r_base};
                        end
                    end
                    if (rd_go) begin
                        rd_nib  = nbtrie_pkg::nibble_of(unit_m, top_idx);
                        n_unit  = unit_m;
                        n_idx   = top_idx;
                        n_state = nbtrie_pkg::S_WALK;
                    end
                end
            end
            nbtrie_pkg::S_WALK: begin
                if (node == 16'd0) begin
                    n_active = 1'b0;
                    n_valid  = 1'b1;
                    n_state  = nbtrie_pkg::S_IDLE;
                end else if (r_idx == 3'd0) begin
                    n_count = count_inc;
                    n_valid = 1'b1;
                    n_state = nbtrie_pkg::S_IDLE;
                    if (node[nbtrie_pkg::LeafBit]) begin
                        n_active = 1'b0;
                        n_status = nbtrie_pkg::ST_FOLDED;
                        n_leaf   = node[14:0];
                        n_units  = count_inc;
                    end else begin
                        n_base   = node[14:0];
                        n_status = nbtrie_pkg::ST_NEED;
                    end
                end else begin
                    // leaf flag inside a unit is just an address, out of range
                    rd_go   = 1'b1;
                    rd_base = node;
                    rd_nib  = nbtrie_pkg::nibble_of(r_unit, next_idx);
                    n_idx   = next_idx;
                end
            end
            default: begin
                n_state = nbtrie_pkg::S_IDLE;
            end
        endcase
        o_mem_req.rd_en   = rd_go;
        o_mem_req.rd_addr = rd_sum[MaxW-1:0];
        n_rd_ok           = rd_go ? (rd_sum < 17'(NODE_DEPTH)) : r_rd_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nbtrie_pkg::S_IDLE;
            r_mode   <= nbtrie_pkg::MODE_8;
            r_base   <= 15'd0;
            r_count  <= 4'd0;
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            r_base   <= n_base;
            r_count  <= n_count;
            r_active <= n_active;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit   <= n_unit;
        r_idx    <= n_idx;
        r_rd_ok  <= n_rd_ok;
        r_status <= n_status;
        r_leaf   <= n_leaf;
        r_units  <= n_units;
    end

    assign busy             = (r_state != nbtrie_pkg::S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_leaf_index     = r_leaf;
    assign o_units_consumed = r_units;

`ifndef SYNTHESIS
    a_wr_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |-> r_state == nbtrie_pkg::S_IDLE)
        else $error("node write during a walk");

    a_rd_when_walking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.rd_en |-> (r_state == nbtrie_pkg::S_WALK) || (start && !busy))
        else $error("node read with no lookup in progress");

    a_folded_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == nbtrie_pkg::ST_FOLDED |-> o_units_consumed != 4'd0)
        else $error("folded result with zero units");

    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != nbtrie_pkg::ST_FOLDED |->
            o_leaf_index == 15'd0 && o_units_consumed == 4'd0)
        else $error("non-folded result carries leaf data");

    a_end_clears_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != nbtrie_pkg::ST_NEED |-> !r_active)
        else $error("lookup still active after it ended");

    a_walk_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == nbtrie_pkg::S_WALK && r_idx == 3'd0 |=>
            o_valid && r_state == nbtrie_pkg::S_IDLE)
        else $error("last nibble gave no result");
`endif

endmodule
`default_nettype wire

### rtl/nibble_trie_casefold_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// node writes give no result; a lookup unit walks one nibble per cycle
// through the node memory read port: up to 2, 4 or 8 reads for 8, 16 or 32-bit units
// result strobe is registered once the node word of the last nibble read comes back (in the cycle after the request
// for units ending without a walk); busy drops with the strobe
// results are shown for one cycle only, the receiver cannot stall
// synchronous active-low reset clears control and width mode; node memory is not cleared
module nibble_trie_casefold_lookup #(
    parameter int NODE_DEPTH = nbtrie_pkg::NodeDepthDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_kind,
    input  wire  [13:0] i_node_addr,
    input  wire  [15:0] i_node_word,
    input  wire  [31:0] i_code_unit,
    input  wire         i_start_req,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [14:0] o_leaf_index,
    output logic [3:0]  o_units_consumed
);

    nbtrie_pkg::t_mem_req mem_req;
    logic [15:0]          mem_rdata;

    nbtrie_mem #(
        .NODE_DEPTH(NODE_DEPTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_rd_data(mem_rdata)
    );

    nbtrie_walk #(
        .NODE_DEPTH(NODE_DEPTH)
    ) u_walk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_node_addr     (i_node_addr),
        .i_node_word     (i_node_word),
        .i_code_unit     (i_code_unit),
        .i_start_req     (i_start_req),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_mem_req       (mem_req),
        .i_mem_rdata     (mem_rdata),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_leaf_index    (o_leaf_index),
        .o_units_consumed(o_units_consumed)
    );

endmodule
`default_nettype wire
